// ===== src/hnorm_pkg.sv =====
// shared types and constants for the heightmap normal generator
package hnorm_pkg;

    localparam int HEIGHT_W = 16;
    localparam int DIFF_W   = 17;
    localparam int GRID_W   = 12;
    localparam int SUM_W    = 34;
    localparam int QUOT_W   = 31;
    localparam int ROOT_W   = 16;
    localparam int NORM_W   = 16;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 8;
    localparam int CFG_W    = 12;
    localparam int DIV_N    = 31;
    localparam int SQRT_N   = 16;

    typedef enum logic [1:0] {
        CFG_COLUMN_COUNT = 2'd0,
        CFG_ROW_COUNT    = 2'd1,
        CFG_GRID_SPACING = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [COL_W-1:0]           col;
        logic [ROW_W-1:0]           row;
        logic signed [HEIGHT_W-1:0] h;
        logic signed [DIFF_W-1:0]   dx;
        logic                       negx;
        logic                       negy;
        logic                       last;
    } meta_t;

endpackage

// ===== src/hnorm_ram2r.sv =====
// generic ram, one write port and two registered read ports
module hnorm_ram2r #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

endmodule

// ===== src/heightmap_normal_generator_core.sv =====
// heightmap normal generator: column store, job issue and normalisation pipeline
//
// Heights arrive one per cycle while s_ready is high, in column-major order; results for
// column c leave while column c+1 streams in, and the final column gives up to three
// results per transaction, so intake waits for the shared pipeline. Each result passes a
// 51-stage pipeline (difference, squares, sum, 31 restoring divide steps, 16 square-root
// steps, rounding) at one result per cycle; the whole pipeline stalls while the output
// register holds a result that is not taken. The column store is a two-read-port ram.
module heightmap_normal_generator_core #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [1:0]                           cfg_index,
    input  logic [hnorm_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [hnorm_pkg::HEIGHT_W-1:0] s_height,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [hnorm_pkg::COL_W-1:0]          m_col_index,
    output logic [hnorm_pkg::ROW_W-1:0]          m_row_index,
    output logic signed [hnorm_pkg::HEIGHT_W-1:0] m_vertex_height,
    output logic signed [hnorm_pkg::NORM_W-1:0]  m_normal_x,
    output logic signed [hnorm_pkg::NORM_W-1:0]  m_normal_y,
    output logic [14:0]                          m_normal_z,
    output logic signed [hnorm_pkg::DIFF_W-1:0]  m_tangent_slope,
    output logic                                 m_frame_last
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int HW = hnorm_pkg::HEIGHT_W;
    localparam int DN = hnorm_pkg::DIV_N;
    localparam int SN = hnorm_pkg::SQRT_N;
    localparam int SW = hnorm_pkg::SUM_W;

    // configuration
    logic [10:0] cols_cfg_reg;
    logic [8:0]  rows_cfg_reg;
    logic [11:0] grid_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= 11'd130;
            rows_cfg_reg <= 9'd130;
            grid_cfg_reg <= 12'd320;
        end else if (cfg_wr_en) begin
            unique case (hnorm_pkg::cfg_idx_t'(cfg_index))
                hnorm_pkg::CFG_COLUMN_COUNT: cols_cfg_reg <= cfg_wr_data[10:0];
                hnorm_pkg::CFG_ROW_COUNT:    rows_cfg_reg <= cfg_wr_data[8:0];
                hnorm_pkg::CFG_GRID_SPACING: grid_cfg_reg <= cfg_wr_data[11:0];
                default: ;
            endcase
        end
    end

    logic [31:0] cols_m1, rows_m1;
    logic [11:0] grid_eff;

    always_comb begin
        if (cols_cfg_reg < 11'd2) cols_m1 = 32'd1;
        else if (32'(cols_cfg_reg) > 32'(MAX_COLUMNS)) cols_m1 = 32'(MAX_COLUMNS - 1);
        else cols_m1 = 32'(cols_cfg_reg) - 32'd1;
        if (rows_cfg_reg < 9'd2) rows_m1 = 32'd1;
        else if (32'(rows_cfg_reg) > 32'(MAX_ROWS)) rows_m1 = 32'(MAX_ROWS - 1);
        else rows_m1 = 32'(rows_cfg_reg) - 32'd1;
        grid_eff = (grid_cfg_reg == 12'd0) ? 12'd1 : grid_cfg_reg;
    end

    // intake and job issue
    logic          adv, accept, issue;
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;
    logic          last_col, last_row;
    logic [2:0]    pend_reg, pend_next, pend_clr;
    logic [CW-1:0] s0_c_reg;
    logic [RW-1:0] s0_r_reg;
    logic signed [HW-1:0] s0_h_reg, prev_h_reg;
    logic          s0_uplast_reg;
    logic [HW-1:0] rd_own, rd_up;

    assign adv      = !m_valid || m_ready;
    assign last_col = 32'(col_cnt_reg) >= cols_m1;
    assign last_row = 32'(row_cnt_reg) >= rows_m1;
    assign s_ready  = (pend_reg == 3'd0) || (adv && $onehot(pend_reg));
    assign accept   = s_valid && s_ready;
    assign issue    = adv && (pend_reg != 3'd0);

    hnorm_ram2r #(.WIDTH(HW), .DEPTH(MAX_ROWS)) u_store (
        .aclk    (aclk),
        .we      (accept),
        .waddr   (row_cnt_reg),
        .wdata   (s_height),
        .re      (accept),
        .raddr_a (row_cnt_reg),
        .raddr_b (row_cnt_reg + RW'(1)),
        .rdata_a (rd_own),
        .rdata_b (rd_up)
    );

    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (last_row) begin
            row_cnt_next = '0;
            col_cnt_next = last_col ? '0 : col_cnt_reg + CW'(1);
        end else begin
            row_cnt_next = row_cnt_reg + RW'(1);
        end
        if (pend_reg[0])      pend_clr = 3'b001;
        else if (pend_reg[1]) pend_clr = 3'b010;
        else                  pend_clr = 3'b100;
        pend_next = pend_reg;
        if (accept) begin
            pend_next = {last_col && last_row, last_col && (row_cnt_reg != '0),
                         col_cnt_reg != '0};
        end else if (issue) begin
            pend_next = pend_reg & ~pend_clr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            pend_reg    <= '0;
        end else begin
            pend_reg <= pend_next;
            if (accept) begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s0_c_reg      <= col_cnt_reg;
            s0_r_reg      <= row_cnt_reg;
            s0_h_reg      <= s_height;
            s0_uplast_reg <= !last_row;
            prev_h_reg    <= s0_h_reg;
        end
    end

    hnorm_pkg::meta_t     job_meta;
    logic signed [HW-1:0] job_own, job_nx, job_ny;

    always_comb begin
        job_meta      = '0;
        job_meta.col  = hnorm_pkg::COL_W'(s0_c_reg);
        job_meta.row  = hnorm_pkg::ROW_W'(s0_r_reg);
        job_own       = s0_h_reg;
        job_nx        = s0_h_reg;
        job_ny        = s0_h_reg;
        if (pend_reg[0]) begin
            job_meta.col = hnorm_pkg::COL_W'(s0_c_reg - CW'(1));
            job_own      = rd_own;
            job_nx       = s0_h_reg;
            job_ny       = s0_uplast_reg ? rd_up : rd_own;
        end else if (pend_reg[1]) begin
            job_meta.row = hnorm_pkg::ROW_W'(s0_r_reg - RW'(1));
            job_own      = prev_h_reg;
            job_nx       = prev_h_reg;
            job_ny       = s0_h_reg;
        end else begin
            job_meta.last = 1'b1;
        end
        job_meta.h = job_own;
    end

    // stage 1: differences
    logic                 st1_vld_reg;
    hnorm_pkg::meta_t     st1_meta_reg, st1_meta_next;
    logic [15:0]          st1_ax_reg, st1_ay_reg;
    logic [11:0]          st1_g_reg;
    logic signed [16:0]   dx_c, dy_c;

    assign dx_c = 17'(job_nx) - 17'(job_own);
    assign dy_c = 17'(job_ny) - 17'(job_own);

    always_comb begin
        st1_meta_next      = job_meta;
        st1_meta_next.dx   = dx_c;
        st1_meta_next.negx = !dx_c[16] && (dx_c != '0);
        st1_meta_next.negy = !dy_c[16] && (dy_c != '0);
    end

    // stage 2: squares
    logic             st2_vld_reg;
    hnorm_pkg::meta_t st2_meta_reg;
    logic [31:0]      st2_sq_reg [3];

    // stage 3: sum
    logic             st3_vld_reg;
    hnorm_pkg::meta_t st3_meta_reg;
    logic [SW-1:0]    st3_s_reg;
    logic [SW-1:0]    st3_rem_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
            st2_vld_reg <= 1'b0;
            st3_vld_reg <= 1'b0;
        end else if (adv) begin
            st1_vld_reg <= issue;
            st2_vld_reg <= st1_vld_reg;
            st3_vld_reg <= st2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_meta_reg      <= st1_meta_next;
            st1_ax_reg        <= dx_c[16] ? 16'(-dx_c) : dx_c[15:0];
            st1_ay_reg        <= dy_c[16] ? 16'(-dy_c) : dy_c[15:0];
            st1_g_reg         <= grid_eff;
            st2_meta_reg      <= st1_meta_reg;
            st2_sq_reg[0]     <= st1_ax_reg * st1_ax_reg;
            st2_sq_reg[1]     <= st1_ay_reg * st1_ay_reg;
            st2_sq_reg[2]     <= 32'(st1_g_reg * st1_g_reg);
            st3_meta_reg      <= st2_meta_reg;
            st3_s_reg         <= SW'(st2_sq_reg[0]) + SW'(st2_sq_reg[1]) + SW'(st2_sq_reg[2]);
            for (int k = 0; k < 3; k++) begin
                st3_rem_reg[k] <= SW'(st2_sq_reg[k]);
            end
        end
    end

    // restoring divide: q = floor(v^2 * 2^30 / s), one bit a stage
    logic             dv_vld_reg  [DN];
    hnorm_pkg::meta_t dv_meta_reg [DN];
    logic [SW-1:0]    dv_s_reg    [DN];
    logic [SW-1:0]    dv_rem_reg  [DN][3];
    logic [30:0]      dv_q_reg    [DN][3];

    for (genvar j = 0; j < DN; j++) begin : g_div
        logic             vin;
        hnorm_pkg::meta_t min;
        logic [SW-1:0]    sin;
        logic [SW:0]      rin [3];
        logic [30:0]      qin [3];

        if (j == 0) begin : g_first
            assign vin = st3_vld_reg;
            assign min = st3_meta_reg;
            assign sin = st3_s_reg;
            for (genvar k = 0; k < 3; k++) begin : g_k
                assign rin[k] = {1'b0, st3_rem_reg[k]};
                assign qin[k] = '0;
            end
        end else begin : g_rest
            assign vin = dv_vld_reg[j-1];
            assign min = dv_meta_reg[j-1];
            assign sin = dv_s_reg[j-1];
            for (genvar k = 0; k < 3; k++) begin : g_k
                assign rin[k] = {dv_rem_reg[j-1][k], 1'b0};
                assign qin[k] = dv_q_reg[j-1][k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[j] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[j] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_meta_reg[j] <= min;
                dv_s_reg[j]    <= sin;
                for (int k = 0; k < 3; k++) begin
                    if (rin[k] >= {1'b0, sin}) begin
                        dv_rem_reg[j][k] <= SW'(rin[k] - {1'b0, sin});
                        dv_q_reg[j][k]   <= {qin[k][29:0], 1'b1};
                    end else begin
                        dv_rem_reg[j][k] <= SW'(rin[k]);
                        dv_q_reg[j][k]   <= {qin[k][29:0], 1'b0};
                    end
                end
            end
        end
    end

    // digit-by-digit square root, one root bit a stage
    logic             sq_vld_reg  [SN];
    hnorm_pkg::meta_t sq_meta_reg [SN];
    logic [31:0]      sq_rad_reg  [SN][3];
    logic [19:0]      sq_rm_reg   [SN][3];
    logic [15:0]      sq_root_reg [SN][3];

    for (genvar j = 0; j < SN; j++) begin : g_sqrt
        logic             vin;
        hnorm_pkg::meta_t min;
        logic [31:0]      radin  [3];
        logic [19:0]      rmin   [3];
        logic [15:0]      rootin [3];
        logic [19:0]      cur    [3];
        logic [19:0]      trial  [3];

        if (j == 0) begin : g_first
            assign vin = dv_vld_reg[DN-1];
            assign min = dv_meta_reg[DN-1];
            for (genvar k = 0; k < 3; k++) begin : g_k
                assign radin[k]  = {1'b0, dv_q_reg[DN-1][k]};
                assign rmin[k]   = '0;
                assign rootin[k] = '0;
            end
        end else begin : g_rest
            assign vin = sq_vld_reg[j-1];
            assign min = sq_meta_reg[j-1];
            for (genvar k = 0; k < 3; k++) begin : g_k
                assign radin[k]  = sq_rad_reg[j-1][k];
                assign rmin[k]   = sq_rm_reg[j-1][k];
                assign rootin[k] = sq_root_reg[j-1][k];
            end
        end

        for (genvar k = 0; k < 3; k++) begin : g_t
            assign cur[k]   = {rmin[k][17:0], radin[k][31:30]};
            assign trial[k] = {2'b00, rootin[k], 2'b01};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[j] <= 1'b0;
            end else if (adv) begin
                sq_vld_reg[j] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_meta_reg[j] <= min;
                for (int k = 0; k < 3; k++) begin
                    sq_rad_reg[j][k] <= {radin[k][29:0], 2'b00};
                    if (cur[k] >= trial[k]) begin
                        sq_rm_reg[j][k]   <= cur[k] - trial[k];
                        sq_root_reg[j][k] <= {rootin[k][14:0], 1'b1};
                    end else begin
                        sq_rm_reg[j][k]   <= cur[k];
                        sq_root_reg[j][k] <= {rootin[k][14:0], 1'b0};
                    end
                end
            end
        end
    end

    // rounding, saturation, sign and output register
    logic [15:0] mag [3];

    always_comb begin
        logic [16:0] rnd;
        for (int k = 0; k < 3; k++) begin
            rnd    = (17'(sq_root_reg[SN-1][k]) + 17'd1) >> 1;
            mag[k] = (rnd > 17'd16384) ? 16'd16384 : rnd[15:0];
        end
    end

    logic out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= sq_vld_reg[SN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_col_index     <= sq_meta_reg[SN-1].col;
            m_row_index     <= sq_meta_reg[SN-1].row;
            m_vertex_height <= sq_meta_reg[SN-1].h;
            m_tangent_slope <= sq_meta_reg[SN-1].dx;
            m_frame_last    <= sq_meta_reg[SN-1].last;
            m_normal_x      <= sq_meta_reg[SN-1].negx ? -mag[0] : mag[0];
            m_normal_y      <= sq_meta_reg[SN-1].negy ? -mag[1] : mag[1];
            m_normal_z      <= mag[2][14:0];
        end
    end

    assign m_valid = out_vld_reg;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the heightmap normal generator core
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic [9:0]         col;
        logic [7:0]         row;
        logic signed [15:0] vh;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [14:0]        nz;
        logic signed [16:0] slope;
        logic               last;
    } normal_res_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [1:0]                      cfg_index;
    logic [hnorm_pkg::CFG_W-1:0]     cfg_wr_data;
    logic                            s_valid;
    logic                            s_ready;
    logic signed [15:0]              s_height;
    logic                            m_valid;
    logic                            m_ready;
    logic [hnorm_pkg::COL_W-1:0]     m_col_index;
    logic [hnorm_pkg::ROW_W-1:0]     m_row_index;
    logic signed [15:0]              m_vertex_height;
    logic signed [15:0]              m_normal_x;
    logic signed [15:0]              m_normal_y;
    logic [14:0]                     m_normal_z;
    logic signed [16:0]              m_tangent_slope;
    logic                            m_frame_last;

    heightmap_normal_generator_core dut (.*);

    // shadow of the block
    logic [10:0]   col_cfg;
    logic [8:0]    row_cfg;
    logic [11:0]   spacing_cfg;
    int            line_store [256];
    int unsigned   col_cnt;
    int unsigned   row_cnt;
    normal_res_t   normals_due [$];

    int            errors = 0;
    int unsigned   cycles = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_req = 0;
    int            hold_cnt = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver back-pressure, with a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [14:0] unit_mag(longint unsigned v, longint unsigned s);
        longint unsigned a, lo, hi, mid, odd;
        a = (v * v) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            odd = 2 * mid - 1;
            if (odd * odd * s <= a) lo = mid;
            else hi = mid - 1;
        end
        return lo[14:0];
    endfunction

    function automatic normal_res_t surface_normal(int unsigned c, int unsigned r, int own,
                                                   int nxh, int nyh, bit last);
        normal_res_t res;
        int dx, dy;
        longint unsigned ax, ay, g, s;
        logic [15:0] mx, my;
        dx = nxh - own;
        dy = nyh - own;
        g = (spacing_cfg == 0) ? 1 : spacing_cfg;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        s = ax * ax + ay * ay + g * g;
        mx = {1'b0, unit_mag(ax, s)};
        my = {1'b0, unit_mag(ay, s)};
        res.col = c[9:0];
        res.row = r[7:0];
        res.vh = own[15:0];
        res.nx = (dx > 0) ? -mx : mx;
        res.ny = (dy > 0) ? -my : my;
        res.nz = unit_mag(g, s);
        res.slope = dx[16:0];
        res.last = last;
        return res;
    endfunction

    task automatic predict_normals(logic signed [15:0] hin);
        int unsigned cols, rows, c, r;
        int h, own, up;
        bit lc, lr;
        h = hin;
        cols = col_cfg;
        rows = row_cfg;
        if (cols < 2) cols = 2;
        if (cols > 1024) cols = 1024;
        if (rows < 2) rows = 2;
        if (rows > 256) rows = 256;
        c = col_cnt;
        r = row_cnt;
        lc = (c >= cols - 1);
        lr = (r >= rows - 1);
        if (c >= 1) begin
            own = line_store[r];
            up = (r + 1 < rows) ? line_store[r + 1] : own;
            normals_due.push_back(surface_normal(c - 1, r, own, h, up, 1'b0));
        end
        if (lc && r >= 1) begin
            own = line_store[r - 1];
            normals_due.push_back(surface_normal(c, r - 1, own, own, h, 1'b0));
        end
        line_store[r] = h;
        if (lc && lr) normals_due.push_back(surface_normal(c, r, h, h, h, 1'b1));
        if (lr) begin
            row_cnt = 0;
            col_cnt = lc ? 0 : c + 1;
        end else begin
            row_cnt = r + 1;
        end
    endtask

    function automatic void check_field(string name, logic signed [63:0] exp_v,
                                        logic signed [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        normal_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (normals_due.size() == 0) begin
                $error("unexpected result transaction at col %0d row %0d",
                       m_col_index, m_row_index);
                errors++;
            end else begin
                e = normals_due.pop_front();
                check_field("col_index", e.col, m_col_index);
                check_field("row_index", e.row, m_row_index);
                check_field("vertex_height", e.vh, m_vertex_height);
                check_field("normal_x", e.nx, m_normal_x);
                check_field("normal_y", e.ny, m_normal_y);
                check_field("normal_z", e.nz, m_normal_z);
                check_field("tangent_slope", e.slope, m_tangent_slope);
                check_field("frame_last", e.last, m_frame_last);
            end
        end
    end

    task automatic send_height(logic signed [15:0] h);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_height <= h;
        do @(posedge aclk); while (!s_ready);
        predict_normals(h);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (normals_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(hnorm_pkg::cfg_idx_t idx, logic [hnorm_pkg::CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            hnorm_pkg::CFG_COLUMN_COUNT: col_cfg = val[10:0];
            hnorm_pkg::CFG_ROW_COUNT:    row_cfg = val[8:0];
            default:                     spacing_cfg = val;
        endcase
    endtask

    task automatic set_grid(int cols, int rows, int g);
        wait_idle();
        write_reg(hnorm_pkg::CFG_COLUMN_COUNT, hnorm_pkg::CFG_W'(cols));
        write_reg(hnorm_pkg::CFG_ROW_COUNT, hnorm_pkg::CFG_W'(rows));
        write_reg(hnorm_pkg::CFG_GRID_SPACING, hnorm_pkg::CFG_W'(g));
    endtask

    function automatic int eff_size(int v, int hi);
        return (v < 2) ? 2 : (v > hi) ? hi : v;
    endfunction

    // smooth terrain with spikes, full-range noise, or random extreme heights, by mode
    task automatic send_frame(int nitems, int mode);
        logic signed [15:0] h;
        h = 16'($urandom);
        for (int i = 0; i < nitems; i++) begin
            case (mode)
                0: h = 16'($urandom);
                1: h = h + $signed(16'($urandom_range(64))) - 16'sd32;
                default: h = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
            endcase
            if (mode == 1 && $urandom_range(19) == 0) h = 16'($urandom);
            send_height(h);
        end
    endtask

    task automatic test_extremes();
        set_grid(2, 2, 1);
        send_height(16'sh7fff);
        send_height(16'sh8000);
        send_height(16'sh8000);
        send_height(16'sh7fff);
        set_grid(3, 3, 4095);
        for (int i = 0; i < 9; i++) send_height(16'sd0);
        set_grid(0, 1, 0);
        send_height(16'sh8000);
        send_height(16'sh7fff);
        send_height(16'sh7fff);
        send_height(16'sh8000);
        set_grid(1, 0, 1);
        send_frame(4, 2);
    endtask

    task automatic test_large_sizes();
        set_grid(2047, 2, 320);
        send_frame(4, 1);
        wait_idle();
        write_reg(hnorm_pkg::CFG_COLUMN_COUNT, hnorm_pkg::CFG_W'(3));
        send_frame(2, 1);
    endtask

    task automatic test_random_frames(int target, int sidle, int rstall);
        int sent, cols, rows;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        sent = 0;
        while (sent < target) begin
            cols = $urandom_range(5, 2);
            rows = $urandom_range(6, 2);
            if ($urandom_range(9) == 0) begin
                cols = $urandom_range(2047);
                if (cols > 6) cols = 1;
            end
            set_grid(cols, rows, ($urandom_range(3) == 0) ? $urandom : $urandom_range(64, 1));
            send_frame(eff_size(cols, 1024) * eff_size(rows, 256), $urandom_range(2));
            sent += eff_size(cols, 1024) * eff_size(rows, 256);
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_grid(3, 16, 100);
        @(negedge aclk);
        hold_req = 200;
        send_frame(48, 1);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = hnorm_pkg::CFG_COLUMN_COUNT;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_height = '0;
        m_ready = 1'b0;
        col_cfg = 130;
        row_cfg = 130;
        spacing_cfg = 320;
        col_cnt = 0;
        row_cnt = 0;
        foreach (line_store[i]) line_store[i] = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_extremes();
        test_large_sizes();
        test_random_frames(10, 0, 0);
        test_random_frames(10, 76, 0);
        test_random_frames(10, 0, 76);
        test_random_frames(10, 18, 18);
        test_backpressure();

        wait_idle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
src/hnorm_pkg.sv
src/hnorm_ram2r.sv
src/heightmap_normal_generator_core.sv
tb/tb.sv
